/* rtl/rtac_pkg.sv */
// Shared types and codes for the region table access checker.
// Holds the entry layout, operation and status codes, and the sequencer states.
// No dependencies; used by rtac_table and region_table_access_check_top.
`default_nettype none

package rtac_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int MAX_REGIONS_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam logic [31:0] WIN_BASE_RST = 32'h0020_0000;
  localparam logic [31:0] WIN_TOP_RST  = 32'hB000_0000;

  // configuration register indexes
  localparam logic CFG_WIN_BASE = 1'b0;
  localparam logic CFG_WIN_TOP  = 1'b1;

  // permission flag bits
  localparam int FLAG_READ_BIT  = 0;
  localparam int FLAG_WRITE_BIT = 1;
  localparam int FLAG_STACK_BIT = 3;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [3:0]           flags_t;

  typedef struct packed {
    flags_t flags;
    addr_t  stop;   // exclusive end
    addr_t  start;
  } entry_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_FIND   = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DENIED    = 2'd1,
    STAT_BAD_RANGE = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/rtac_table.sv */
// Region entry store: one write port, one read port with registered read data.
// Depends on rtac_pkg for the entry layout.
`default_nettype none

module rtac_table #(
  parameter int DEPTH = rtac_pkg::MAX_REGIONS_DEF,
  parameter int IDX_W = $clog2(rtac_pkg::MAX_REGIONS_DEF)
) (
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output rtac_pkg::entry_t       rd_data,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire rtac_pkg::entry_t  wr_data
);

  rtac_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/region_table_access_check_top.sv */
// Region table access checker: sorted region table with clear, insert, find and check.
// Depends on rtac_pkg and rtac_table.
`default_nettype none

// Usage
//   Input stream (s_*): one operation per transfer, accepted only while the
//   sequencer is idle and out of reset. s_tuser carries the operation code.
//   Output stream (m_*): exactly one result per operation, held in an output
//   register until the receiver takes it; a stalled receiver only delays the
//   return to idle, the finished result is never overwritten.
//   Config channel (cfg_*): ready outside reset; write window registers while idle.
// Sequence per operation: the start state, then the table walk for find, check
// and insert, then for an insert the shift of later entries and the placement of
// the new entry, then the done state that loads the result. Clear, and operations
// rejected at the start, go straight to the done state.
// The table walk reads one entry per cycle from the entry store, and an
// insert then moves each later entry up one slot, one store write per cycle.
// The next operation is accepted the cycle after the result is loaded, so
// operations never overlap, and a stalled receiver holds off the next one.
// Reset (rst, synchronous) empties the table and restores the window
// registers; entry contents stay undefined until written.

module region_table_access_check_top #(
  parameter int MAX_REGIONS = rtac_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_BYTES  = rtac_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // address[31:0], extent[63:32], perm_flags[67:64],
                                      // is_write[68], zero fill
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // hit_start[31:0], hit_end[63:32], hit_flags[67:64],
                                      // region_count[72:68], zero fill
  output logic [1:0]       m_tuser,   // status[1:0]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);
  localparam rtac_pkg::addr_t PAGE_SPAN = rtac_pkg::addr_t'(PAGE_BYTES);

  rtac_pkg::state_t state, state_next;

  rtac_pkg::op_t    op;
  rtac_pkg::addr_t  key;       // insert start, find address, check cursor
  rtac_pkg::addr_t  lim;       // insert end, check stop
  rtac_pkg::flags_t flg;
  logic             wr;
  logic [CW-1:0]    used;
  logic [CW-1:0]    idx;       // entry index held in rd_data
  logic [CW-1:0]    w;         // shift destination
  rtac_pkg::addr_t  prev_end;
  logic             have_prev;
  rtac_pkg::addr_t  win_base, win_top;

  rtac_pkg::status_t res_status;
  rtac_pkg::entry_t  res_entry;

  logic [IW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  rtac_pkg::entry_t  rd_data, wr_data, new_entry;

  logic              fin, fin_hit, adv, shift_go, out_free;
  rtac_pkg::status_t fin_status;

  rtac_pkg::entry_t e;
  rtac_pkg::addr_t  stop_sum;
  logic             in_range, below, contains, overlap, stack_hit, need_ok;
  logic [CW-1:0]    idx_inc, used_m1, w_m1, w_m2;

  rtac_table #(.DEPTH(MAX_REGIONS), .IDX_W(IW)) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign s_tready  = (state == rtac_pkg::S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign out_free  = !m_tvalid || m_tready;

  assign e         = rd_data;
  assign new_entry = '{flags: flg, stop: lim, start: key};
  assign stop_sum  = key + lim;
  assign idx_inc   = idx + CW'(1);
  assign used_m1   = used - CW'(1);
  assign w_m1      = w - CW'(1);
  assign w_m2      = w - CW'(2);

  assign in_range  = idx < used;
  assign below     = in_range && (e.start <= key);
  assign contains  = below && (key < e.stop);
  assign overlap   = (have_prev && (prev_end > key)) || (in_range && (lim > e.start));
  assign stack_hit = e.flags[rtac_pkg::FLAG_STACK_BIT] && ((key - e.start) < PAGE_SPAN);
  assign need_ok   = wr ? e.flags[rtac_pkg::FLAG_WRITE_BIT] : e.flags[rtac_pkg::FLAG_READ_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx[IW-1:0];
    wr_data    = new_entry;
    fin        = 1'b0;
    fin_status = rtac_pkg::STAT_OK;
    fin_hit    = 1'b0;
    adv        = 1'b0;
    shift_go   = 1'b0;
    unique case (state)
      rtac_pkg::S_IDLE: begin
        if (s_tvalid) state_next = rtac_pkg::S_START;
      end
      rtac_pkg::S_START: begin
        unique case (op)
          rtac_pkg::OP_CLEAR: fin = 1'b1;
          rtac_pkg::OP_INSERT: begin
            if (key >= lim) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_BAD_RANGE;
            end else begin
              state_next = rtac_pkg::S_SCAN;
            end
          end
          rtac_pkg::OP_FIND: state_next = rtac_pkg::S_SCAN;
          rtac_pkg::OP_CHECK: begin
            if (win_base <= key && key < stop_sum && stop_sum <= win_top) begin
              state_next = rtac_pkg::S_SCAN;
            end else begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_DENIED;
            end
          end
        endcase
      end
      rtac_pkg::S_SCAN: begin
        // prefetch the next entry while this one is judged
        rd_addr = idx_inc[IW-1:0];
        unique case (op)
          rtac_pkg::OP_FIND: begin
            if (!in_range) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_DENIED;
            end else if (contains) begin
              fin     = 1'b1;
              fin_hit = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          rtac_pkg::OP_INSERT: begin
            if (below) begin
              adv = 1'b1;
            end else if (overlap) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_BAD_RANGE;
            end else if (used >= MAX_CNT) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_FULL;
            end else if (in_range) begin
              // open a slot at idx: move entries up from the top
              shift_go   = 1'b1;
              rd_addr    = used_m1[IW-1:0];
              state_next = rtac_pkg::S_SHIFT;
            end else begin
              state_next = rtac_pkg::S_PLACE;
            end
          end
          rtac_pkg::OP_CHECK: begin
            if (key >= lim) begin
              fin = 1'b1;
            end else if (!in_range) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_DENIED;
            end else if (contains) begin
              if (!need_ok || (wr && stack_hit)) begin
                fin        = 1'b1;
                fin_status = rtac_pkg::STAT_DENIED;
              end else begin
                adv = 1'b1;
              end
            end else if (e.start > key) begin
              fin        = 1'b1;
              fin_status = rtac_pkg::STAT_DENIED;
            end else begin
              adv = 1'b1;
            end
          end
          rtac_pkg::OP_CLEAR: fin = 1'b1;
        endcase
      end
      rtac_pkg::S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = w[IW-1:0];
        wr_data = rd_data;
        rd_addr = w_m2[IW-1:0];
        if (w_m1 == idx) state_next = rtac_pkg::S_PLACE;
      end
      rtac_pkg::S_PLACE: begin
        wr_en = 1'b1;
        fin   = 1'b1;
      end
      rtac_pkg::S_DONE: begin
        if (out_free) state_next = rtac_pkg::S_IDLE;
      end
      default: state_next = rtac_pkg::S_IDLE;
    endcase
    if (fin) state_next = rtac_pkg::S_DONE;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      m_tvalid <= 1'b0;
      win_base <= rtac_pkg::WIN_BASE_RST;
      win_top  <= rtac_pkg::WIN_TOP_RST;
    end else begin
      if (state == rtac_pkg::S_START && op == rtac_pkg::OP_CLEAR) begin
        used <= '0;
      end else if (state == rtac_pkg::S_PLACE) begin
        used <= used + CW'(1);
      end
      if (state == rtac_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtac_pkg::CFG_WIN_BASE: win_base <= cfg_data;
          rtac_pkg::CFG_WIN_TOP:  win_top  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == rtac_pkg::S_IDLE && s_tvalid) begin
      op  <= rtac_pkg::op_t'(s_tuser);
      key <= s_tdata[31:0];
      lim <= s_tdata[63:32];
      flg <= s_tdata[67:64];
      wr  <= s_tdata[68];
    end
    if (state == rtac_pkg::S_START) begin
      idx       <= '0;
      have_prev <= 1'b0;
      if (op == rtac_pkg::OP_CHECK) lim <= stop_sum;
    end
    if (adv) begin
      idx <= idx_inc;
      if (op == rtac_pkg::OP_INSERT) begin
        prev_end  <= e.stop;
        have_prev <= 1'b1;
      end
      // advance the check cursor past the covering region
      if (op == rtac_pkg::OP_CHECK && contains) key <= e.stop;
    end
    if (shift_go) begin
      w <= used;
    end else if (state == rtac_pkg::S_SHIFT) begin
      w <= w_m1;
    end
    if (fin) begin
      res_status <= fin_status;
      res_entry  <= fin_hit ? rd_data : '0;
    end
    if (state == rtac_pkg::S_DONE && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {7'b0, 5'(used), res_entry.flags, res_entry.stop, res_entry.start};
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= MAX_CNT)
    else $error("region count exceeds table depth");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    state == rtac_pkg::S_SCAN |-> idx <= used)
    else $error("table walk ran past the last region");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == rtac_pkg::S_SHIFT |-> (w > idx) && (w < MAX_CNT))
    else $error("shift destination outside the open slot range");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    state == rtac_pkg::S_START && op == rtac_pkg::OP_CLEAR |=> used == '0)
    else $error("clear left regions in the table");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != rtac_pkg::STAT_OK |-> m_tdata[67:0] == '0)
    else $error("failed operation returned region fields");

endmodule

`default_nettype wire
